// ----- hw/rtl/task_runtime_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// task_runtime_accumulator_macros
// assertion helpers shared by the accumulator rtl
// ----------------------------------------------------------------------------
`ifndef TASK_RUNTIME_ACCUMULATOR_MACROS_SVH
`define TASK_RUNTIME_ACCUMULATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define TRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/trt_pkg.sv -----
// ----------------------------------------------------------------------------
// trt_pkg
// shared types and constants of the task run-time accumulator
// ----------------------------------------------------------------------------
package trt_pkg;

    localparam int TASKS_DEF = 16;
    localparam int SLOT_W    = 5;
    localparam int TICK_W    = 16;
    localparam int DATA_W    = 32;

    localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd3600000000;

    typedef enum logic [1:0] {
        OP_SWITCH_IN  = 2'd0,
        OP_SWITCH_OUT = 2'd1,
        OP_READ       = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } cmd_t;

endpackage

// ----- hw/rtl/trt_ram.sv -----
// ----------------------------------------------------------------------------
// trt_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module trt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/trt_ctrl.sv -----
// ----------------------------------------------------------------------------
// trt_ctrl
// handshake controller: takes a beat, then commits it into the output register
// ----------------------------------------------------------------------------
module trt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output trt_pkg::cmd_t cmd
);

    import trt_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.commit    = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- hw/rtl/trt_datapath.sv -----
// ----------------------------------------------------------------------------
// trt_datapath
// slot totals, switch bookkeeping and result registers
// ----------------------------------------------------------------------------
module trt_datapath #(
    parameter int TASKS = trt_pkg::TASKS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  trt_pkg::cmd_t               cmd,
    input  logic                        cfg_wr_en,
    input  logic [trt_pkg::DATA_W-1:0]  cfg_wr_data,
    input  trt_pkg::op_t                in_op,
    input  logic [trt_pkg::SLOT_W-1:0]  in_slot,
    input  logic [trt_pkg::TICK_W-1:0]  in_tick,
    input  logic [trt_pkg::DATA_W-1:0]  in_uptime,
    output logic [trt_pkg::DATA_W-1:0]  out_read_value,
    output logic [trt_pkg::DATA_W-1:0]  out_elapsed,
    output logic                        out_limit_reset
);

    import trt_pkg::*;

    localparam int TRACKED = TASKS + 2;
    localparam int AW      = $clog2(TRACKED);

    localparam logic [SLOT_W-1:0] SLOT_IDLE    = SLOT_W'(TASKS);
    localparam logic [SLOT_W-1:0] SLOT_OTHER   = SLOT_W'(TASKS + 2);
    localparam logic [SLOT_W-1:0] SLOT_TRACKED = SLOT_W'(TRACKED);

    // latched beat
    op_t               op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [DATA_W-1:0] uptime_reg;
    logic [AW-1:0]     addr_reg;
    logic              track_reg;
    logic              hit_reg;

    // block state
    logic [SLOT_W-1:0]  cur_slot_reg, cur_slot_next;
    logic [TICK_W-1:0]  start_tick_reg, start_tick_next;
    logic [DATA_W-1:0]  start_uptime_reg, start_uptime_next;
    logic [DATA_W-1:0]  limit_reg;
    logic [TRACKED-1:0] valid_reg, valid_next;

    // result
    logic [DATA_W-1:0] read_value_reg, read_value_next;
    logic [DATA_W-1:0] elapsed_reg, elapsed_next;
    logic              flag_reg, flag_next;

    logic [SLOT_W-1:0] sel_slot;
    logic              sel_track;
    logic [AW-1:0]     sel_addr;
    logic [DATA_W-1:0] ram_rd_data;
    logic [DATA_W-1:0] old_total;
    logic [DATA_W-1:0] sum;
    logic [TICK_W-1:0] diff;
    logic              ram_wr_en;
    logic              clear_all;

    // lookup address for the accepted beat
    always_comb begin
        sel_slot  = (in_op == OP_READ) ? in_slot : cur_slot_reg;
        sel_track = sel_slot < SLOT_TRACKED;
        sel_addr  = sel_slot[AW-1:0];
    end

    trt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TRACKED)
    ) u_totals (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (sum),
        .rd_en   (cmd.accept),
        .rd_addr (sel_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg     <= in_op;
            slot_reg   <= in_slot;
            tick_reg   <= in_tick;
            uptime_reg <= in_uptime;
            addr_reg   <= sel_addr;
            track_reg  <= sel_track;
            hit_reg    <= sel_track && valid_reg[sel_addr];
        end
        if (cmd.commit) begin
            read_value_reg <= read_value_next;
            elapsed_reg    <= elapsed_next;
            flag_reg       <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_slot_reg     <= SLOT_IDLE;
            start_tick_reg   <= '0;
            start_uptime_reg <= '0;
            limit_reg        <= LIMIT_RESET;
            valid_reg        <= '0;
        end else begin
            if (cmd.commit) begin
                cur_slot_reg     <= cur_slot_next;
                start_tick_reg   <= start_tick_next;
                start_uptime_reg <= start_uptime_next;
                valid_reg        <= valid_next;
            end
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        diff              = tick_reg - start_tick_reg;
        old_total         = hit_reg ? ram_rd_data : '0;
        sum               = old_total + DATA_W'(diff);
        cur_slot_next     = cur_slot_reg;
        start_tick_next   = start_tick_reg;
        start_uptime_next = start_uptime_reg;
        valid_next        = valid_reg;
        read_value_next   = '0;
        flag_next         = 1'b0;
        ram_wr_en         = 1'b0;
        clear_all         = 1'b0;
        unique case (op_reg)
            OP_SWITCH_IN: begin
                cur_slot_next   = (slot_reg > SLOT_OTHER) ? SLOT_OTHER : slot_reg;
                start_tick_next = tick_reg;
            end
            OP_SWITCH_OUT: begin
                if (track_reg) begin
                    if (sum > limit_reg) begin
                        clear_all = 1'b1;
                        flag_next = 1'b1;
                    end else begin
                        ram_wr_en            = cmd.commit;
                        valid_next[addr_reg] = 1'b1;
                    end
                end
            end
            OP_READ: begin
                read_value_next = old_total;
            end
            OP_CLEAR: begin
                clear_all = 1'b1;
            end
            default: begin
                clear_all = 1'b0;
            end
        endcase
        if (clear_all) begin
            valid_next        = '0;
            cur_slot_next     = SLOT_IDLE;
            start_uptime_next = uptime_reg;
        end
        elapsed_next = clear_all ? '0 : uptime_reg - start_uptime_reg;
    end

    assign out_read_value  = read_value_reg;
    assign out_elapsed     = elapsed_reg;
    assign out_limit_reset = flag_reg;

endmodule

// ----- hw/rtl/task_runtime_accumulator.sv -----
// ----------------------------------------------------------------------------
// task_runtime_accumulator
// per-slot run-time totals with switch-in, switch-out, read and clear
//
// Each beat is handled in order: the idle state latches it and reads the slot
// total from the totals ram, then the exec state adds, compares against the
// limit and writes back. The next beat is taken in the cycle after the exec
// state commits; a held result keeps the exec state waiting, and no new beat is
// taken until the last one is committed. Clearing all totals resets the
// per-slot valid bits rather than the ram, so a clear or a limit overflow costs nothing extra.
// Each beat gives exactly one result beat. collect_limit may be written
// whenever no beat is in flight.
// ----------------------------------------------------------------------------
module task_runtime_accumulator #(
    parameter int TASKS = trt_pkg::TASKS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [trt_pkg::DATA_W-1:0] cfg_wr_data,   // collect_limit
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [55:0]                s_tdata,       // task_slot, tick_now, uptime_ms, zero pad
    input  logic [1:0]                 s_tuser,       // operation
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,       // read_value, elapsed_ms
    output logic [0:0]                 m_tuser        // limit_reset
);

    import trt_pkg::*;

    `include "task_runtime_accumulator_macros.svh"

    cmd_t              cmd;
    logic [DATA_W-1:0] read_value;
    logic [DATA_W-1:0] elapsed;
    logic              limit_reset;

    trt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    trt_datapath #(
        .TASKS (TASKS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_op           (op_t'(s_tuser)),
        .in_slot         (s_tdata[4:0]),
        .in_tick         (s_tdata[20:5]),
        .in_uptime       (s_tdata[52:21]),
        .out_read_value  (read_value),
        .out_elapsed     (elapsed),
        .out_limit_reset (limit_reset)
    );

    assign m_tdata = {elapsed, read_value};
    assign m_tuser = limit_reset;

    `TRT_ASSERT_NEXT(a_one_beat_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "beat taken while another is in flight")
    `TRT_ASSERT_NEXT(a_commit_shows_result, aclk, aresetn, cmd.commit, m_tvalid, "committed result not presented")
    `TRT_ASSERT_NOW(a_limit_reset_clean, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 64'd0, "limit reset with nonzero payload")
    `TRT_ASSERT_NOW(a_commit_exclusive, aclk, aresetn, cmd.commit, !cmd.accept && !s_tready, "commit overlaps accept")

endmodule
